### sv/llerode_pkg.sv
// Shared widths, limits and result type for the landlocked mask erosion block.
`timescale 1ns / 1ps
`default_nettype none

package llerode_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam int CFG_W  = 11;   // width of lat_rows / lon_cols
  localparam int IDX_W  = 10;   // width of reported row / column
  localparam int CNT_W  = 21;   // width of running counts
  localparam int TOUT_W = 64;   // m_tdata width
  localparam int TIN_W  = 8;    // s_tdata width

  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(1 << 20);

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_LAT_ROWS = 1'b0,
    REG_LON_COLS = 1'b1
  } cfg_reg_t;

  // input word kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  // per-column row history: bit 1 = newest stored row, bit 0 = the row before it
  typedef logic [1:0] hist_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             landlocked;
    logic             coastal;
    logic [CNT_W-1:0] coastal_count;
    logic [CNT_W-1:0] landlocked_count;
    logic             grid_done;
  } res_t;

endpackage

`default_nettype wire

### sv/llerode_hist_mem.sv
// Per-column two-row history memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module llerode_hist_mem (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [llerode_pkg::COL_W-1:0] wa,
  input  wire llerode_pkg::hist_t        wd,
  input  wire logic [llerode_pkg::COL_W-1:0] ra,
  input  wire logic [llerode_pkg::COL_W-1:0] rb,
  output llerode_pkg::hist_t             qa,
  output llerode_pkg::hist_t             qb
);
  import llerode_pkg::*;

  hist_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // forward the word being written so a read of the same column sees it
  always_ff @(posedge clk) begin
    qa <= (we && (wa == ra)) ? wd : mem[ra];
    qb <= (we && (wa == rb)) ? wd : mem[rb];
  end

endmodule

`default_nettype wire

### sv/llerode_out_skid.sv
// Two-entry output buffer: result register plus a skid register.
`timescale 1ns / 1ps
`default_nettype none

module llerode_out_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              res_valid,
  input  wire llerode_pkg::res_t res,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output llerode_pkg::res_t      out_res
);
  import llerode_pkg::*;

  logic prim_valid;
  logic skid_valid;
  res_t prim;
  res_t skid;

  assign in_ready  = !skid_valid;
  assign out_valid = prim_valid;
  assign out_res   = prim;

  always_ff @(posedge clk) begin
    if (rst) begin
      prim_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!prim_valid || out_ready) begin
      if (skid_valid) begin
        prim_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        prim_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!prim_valid || out_ready) begin
      prim <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

endmodule

`default_nettype wire

### sv/landlocked_mask_cross_erosion_top.sv
// Top level: streaming four-neighbour cross erosion of a land/water mask.
//
//  channel | dir | fields (low bit first)                            | handshake
//  --------+-----+---------------------------------------------------+-------------------
//  s_*     | in  | tdata: water[0], zero pad; tuser: mode            | s_tvalid/s_tready
//  m_*     | out | tdata: row, col, landlocked, coastal, counts;     | m_tvalid/m_tready
//          |     | tlast: grid_done                                  |
//  cfg_*   | in  | cfg_index selects lat_rows / lon_cols             | cfg_we, no wait
//
// One word is taken every cycle while s_tready is high; its result, if any, is registered
// in the output register, or in the skid register on a stall. All evaluation for a word
// is one pass through the window logic fed by the two registered history-memory reads
// and a few edge registers. s_tready drops only when both the output register and the
// skid register hold words. Reset needs no memory sweep: the scan order writes every
// column of the history before any reported point reads it.
`timescale 1ns / 1ps
`default_nettype none

module landlocked_mask_cross_erosion_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [llerode_pkg::TIN_W-1:0]  s_tdata,   // [0] water, [7:1] zero
  input  wire logic                        s_tuser,   // [0] mode
  // result stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [llerode_pkg::TOUT_W-1:0]   m_tdata,   // [9:0] row_index, [19:10] col_index,
                                                      // [20] landlocked, [21] coastal,
                                                      // [42:22] coastal_count,
                                                      // [63:43] landlocked_count
  output logic                             m_tlast,   // grid_done
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [llerode_pkg::CFG_W-1:0]  cfg_data
);
  import llerode_pkg::*;

  // clamp a size register to 1..maxv
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  localparam logic [CFG_W-1:0] COLS_MAX = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] ROWS_MAX = CFG_W'(MAX_ROWS);

  // configuration and scan state
  logic [CFG_W-1:0] rows_lim, rows_lim_next;
  logic [CFG_W-1:0] cols_lim, cols_lim_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [COL_W-1:0] drain_col, drain_col_next;
  logic             draining, draining_next;
  logic [CNT_W-1:0] coastal_total, coastal_total_next;
  logic [CNT_W-1:0] landlocked_total, landlocked_total_next;
  // window edge registers
  logic             west_mid, west_mid_next;    // middle-row bit one column back
  logic             first_mid, first_mid_next;  // middle-row bit of column 0
  logic             last_mid, last_mid_next;    // middle-row bit of the last column

  // history memory
  hist_t            rd_a, rd_b;
  logic [COL_W-1:0] ra, rb;
  logic             mem_we;
  hist_t            mem_wd;

  // datapath
  logic             in_fire;
  logic             water;
  logic             samp, drn, emit;
  logic [COL_W-1:0] col;
  logic             col_first, col_last, row_last;
  logic             own_mid, own_above, west, east;
  logic [ROW_W-1:0] rr;
  logic             land, locked, coast;
  logic [CNT_W-1:0] cc_upd, lc_upd;
  logic [COL_W-1:0] col_nx;
  res_t             res;
  res_t             out_res;

  assign in_fire = s_tvalid && s_tready;
  assign water   = s_tdata[0];

  // sample words are dropped while draining, drain ticks outside of draining
  assign samp = in_fire && (s_tuser == MODE_SAMPLE) && !draining;
  assign drn  = in_fire && (s_tuser == MODE_DRAIN) && draining;
  assign emit = (samp && (cur_row != '0)) || drn;

  assign col       = draining ? drain_col : cur_col;
  assign col_first = (col == '0);
  assign col_last  = ((CFG_W'(col) + CFG_W'(1)) == cols_lim);
  assign row_last  = ((CFG_W'(cur_row) + CFG_W'(1)) == rows_lim);

  assign own_mid   = rd_a[1];
  assign own_above = rd_a[0];

  // west of column 0 wraps to the last column of the middle row
  assign west = col_first ? last_mid : west_mid;

  // while sampling, column 0 of the history already holds the new row, so the
  // wrapped east neighbor comes from the captured copy; drain has no writes
  always_comb begin
    if (draining || !col_last) begin
      east = rd_b[1];
    end else if (col_first) begin
      east = own_mid;
    end else begin
      east = first_mid;
    end
  end

  assign rr = draining ? ROW_W'(rows_lim - CFG_W'(1)) : (cur_row - ROW_W'(1));

  assign land   = !own_mid;
  assign locked = land && !west && !east
                  && !((rr != '0) && own_above)
                  && !(!draining && water);
  assign coast  = land && !locked;

  // saturating running counts
  assign cc_upd = (coast && (coastal_total < COUNT_CAP)) ?
                  coastal_total + CNT_W'(1) : coastal_total;
  assign lc_upd = (locked && (landlocked_total < COUNT_CAP)) ?
                  landlocked_total + CNT_W'(1) : landlocked_total;

  always_comb begin
    res.row_index        = IDX_W'(rr);
    res.col_index        = IDX_W'(col);
    res.landlocked       = locked;
    res.coastal          = coast;
    res.coastal_count    = cc_upd;
    res.landlocked_count = lc_upd;
    res.grid_done        = draining && col_last;
  end

  // next state
  always_comb begin
    rows_lim_next         = rows_lim;
    cols_lim_next         = cols_lim;
    cur_row_next          = cur_row;
    cur_col_next          = cur_col;
    drain_col_next        = drain_col;
    draining_next         = draining;
    coastal_total_next    = coastal_total;
    landlocked_total_next = landlocked_total;
    west_mid_next         = west_mid;
    first_mid_next        = first_mid;
    last_mid_next         = last_mid;

    if (cfg_we) begin
      // any register write restarts the grid
      unique case (cfg_reg_t'(cfg_index))
        REG_LAT_ROWS: rows_lim_next = clamp_size(cfg_data, ROWS_MAX);
        REG_LON_COLS: cols_lim_next = clamp_size(cfg_data, COLS_MAX);
        default:      rows_lim_next = rows_lim;
      endcase
      cur_row_next          = '0;
      cur_col_next          = '0;
      drain_col_next        = '0;
      draining_next         = 1'b0;
      coastal_total_next    = '0;
      landlocked_total_next = '0;
    end else if (samp) begin
      west_mid_next = own_mid;
      if (col_first) begin
        first_mid_next = own_mid;
      end
      if (emit) begin
        coastal_total_next    = cc_upd;
        landlocked_total_next = lc_upd;
      end
      if (col_last) begin
        // row complete: the incoming row becomes the middle row
        cur_col_next  = '0;
        last_mid_next = water;
        if (row_last) begin
          cur_row_next  = '0;
          draining_next = 1'b1;
        end else begin
          cur_row_next = cur_row + ROW_W'(1);
        end
      end else begin
        cur_col_next = cur_col + COL_W'(1);
      end
    end else if (drn) begin
      west_mid_next = own_mid;
      if (col_last) begin
        // final point reported: start a fresh grid
        drain_col_next        = '0;
        draining_next         = 1'b0;
        coastal_total_next    = '0;
        landlocked_total_next = '0;
      end else begin
        drain_col_next        = drain_col + COL_W'(1);
        coastal_total_next    = cc_upd;
        landlocked_total_next = lc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_lim         <= ROWS_MAX;
      cols_lim         <= COLS_MAX;
      cur_row          <= '0;
      cur_col          <= '0;
      drain_col        <= '0;
      draining         <= 1'b0;
      coastal_total    <= '0;
      landlocked_total <= '0;
    end else begin
      rows_lim         <= rows_lim_next;
      cols_lim         <= cols_lim_next;
      cur_row          <= cur_row_next;
      cur_col          <= cur_col_next;
      drain_col        <= drain_col_next;
      draining         <= draining_next;
      coastal_total    <= coastal_total_next;
      landlocked_total <= landlocked_total_next;
    end
  end

  // edge bits are rewritten before any reported point uses them
  always_ff @(posedge clk) begin
    west_mid  <= west_mid_next;
    first_mid <= first_mid_next;
    last_mid  <= last_mid_next;
  end

  // prefetch the column the next word will evaluate, and its east neighbor
  always_comb begin
    if (rst) begin
      col_nx = '0;
    end else begin
      col_nx = draining_next ? drain_col_next : cur_col_next;
    end
    ra = col_nx;
    if ((CFG_W'(col_nx) + CFG_W'(1)) == cols_lim_next) begin
      rb = '0;
    end else begin
      rb = col_nx + COL_W'(1);
    end
  end

  // shift the column history: new sample on top, old middle bit below
  assign mem_we = samp;
  assign mem_wd = {water, own_mid};

  llerode_hist_mem u_hist (
    .clk (clk),
    .we  (mem_we),
    .wa  (cur_col),
    .wd  (mem_wd),
    .ra  (ra),
    .rb  (rb),
    .qa  (rd_a),
    .qb  (rd_b)
  );

  llerode_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (emit),
    .res       (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.landlocked_count, out_res.coastal_count,
                    out_res.coastal, out_res.landlocked,
                    out_res.col_index, out_res.row_index};
  assign m_tlast = out_res.grid_done;

endmodule

`default_nettype wire

### sv/llerode_checker.sv
// Port-level checks for the landlocked mask erosion top level, with bind.
`timescale 1ns / 1ps
`default_nettype none

module llerode_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [llerode_pkg::TOUT_W-1:0]   m_tdata
);
  import llerode_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input stalls only when a result is pending
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // a point is never both coastal and landlocked
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[20] && m_tdata[21]))
    else $error("point both coastal and landlocked");

  // running counts saturate at the cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[42:22] <= COUNT_CAP) && (m_tdata[63:43] <= COUNT_CAP))
    else $error("count above cap");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind landlocked_mask_cross_erosion_top llerode_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
